/* design/wcb_pkg.sv */
// Package with shared constants and types of the WiSARD bleaching classifier.
package wcb_pkg;
	localparam int CLASSES_DEF    = 8;
	localparam int PIXELS_DEF     = 64;
	localparam int TUPLE_DEF      = 4;
	localparam int COUNT_BITS_DEF = 8;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_CLASS = 2'd2;

	localparam logic [1:0] ST_UNIQUE  = 2'd0;
	localparam logic [1:0] ST_TIE     = 2'd1;
	localparam logic [1:0] ST_ZERO    = 2'd2;
	localparam logic [1:0] ST_UNTRAIN = 2'd3;

	localparam logic CFG_BLEACH = 1'b0;
	localparam logic CFG_CLASSES = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_TRAIN,
		S_SCORE,
		S_DECIDE,
		S_OUT
	} state_t;

	// Lane control handed from the sequencer to the neuron lanes.
	typedef struct packed {
		logic clear;
		logic train;
		logic score;
	} lane_ctl_t;
endpackage

/* design/wcb_lane.sv */
// One neuron lane: address forming, counter memory, and threshold compare.
module wcb_lane #(
	parameter int CLASSES    = wcb_pkg::CLASSES_DEF,
	parameter int TUPLE      = wcb_pkg::TUPLE_DEF,
	parameter int COUNT_BITS = wcb_pkg::COUNT_BITS_DEF,
	parameter int CW         = (CLASSES > 1) ? $clog2(CLASSES) : 1
) (
	input  logic                  clk,
	input  wcb_pkg::lane_ctl_t    ctl,
	input  logic [TUPLE-1:0]      addr,
	input  logic [CW-1:0]         cls,
	input  logic [CW-1:0]         clr_cls,
	input  logic [TUPLE-1:0]      clr_addr,
	input  logic [7:0]            level,
	output logic                  hit
);
	import wcb_pkg::*;
	localparam int DEPTH = CLASSES * (1 << TUPLE);
	localparam int AW = $clog2(DEPTH);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_q;
	logic [AW-1:0]         ra;
	logic [AW-1:0]         wa_q;
	logic                  inc_q;

	assign ra = AW'(cls) * AW'(1 << TUPLE) + AW'(addr);

	// Read is registered; a training increment is written in the cycle after the read.
	always_ff @(posedge clk) begin
		rd_q  <= mem[ra];
		wa_q  <= ra;
		inc_q <= ctl.train;
		if (ctl.clear) begin
			mem[AW'(clr_cls) * AW'(1 << TUPLE) + AW'(clr_addr)] <= '0;
		end else if (inc_q && rd_q != CMAX) begin
			mem[wa_q] <= rd_q + 1'b1;
		end
	end

	always_comb begin
		if (COUNT_BITS >= 8) hit = rd_q > COUNT_BITS'(level);
		else hit = {8'd0, rd_q} > {{COUNT_BITS{1'b0}}, level};
	end
endmodule

/* design/wcb_merge.sv */
// Merging stage: counts lane hits into a class score and tracks best and ties.
module wcb_merge #(
	parameter int CLASSES = wcb_pkg::CLASSES_DEF,
	parameter int NEURONS = wcb_pkg::PIXELS_DEF / wcb_pkg::TUPLE_DEF,
	parameter int CW      = (CLASSES > 1) ? $clog2(CLASSES) : 1,
	parameter int SW      = $clog2(NEURONS + 1)
) (
	input  logic               clk,
	input  logic               start,
	input  logic               valid,
	input  logic [CW-1:0]      cls,
	input  logic [NEURONS-1:0] hits,
	output logic [SW-1:0]      top,
	output logic [CW-1:0]      best,
	output logic [CLASSES-1:0] mask,
	output logic [4:0]         ties
);
	import wcb_pkg::*;
	logic [SW-1:0] score;

	always_comb begin
		score = '0;
		for (int n = 0; n < NEURONS; n++) score = score + SW'(hits[n]);
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			if (start || score > top) begin
				top  <= score;
				best <= cls;
				mask <= CLASSES'(1) << cls;
				ties <= 5'd1;
			end else if (score == top) begin
				mask[cls] <= 1'b1;
				ties <= ties + 5'd1;
			end
		end
	end
endmodule

/* design/wisard_classifier_bleaching_core.sv */
// Top level of the WiSARD weightless classifier with bleaching.
// Load writes the slot map when the word is taken; train reads the label's counters in the
// train state; classify sweeps the classes level by level, then decides and sets the result word.
// One neuron lane per neuron reads its counter memory in parallel, one class per cycle.
// The result word sits in an output register; the next word is taken while it waits.
// After reset a clearing pass zeroes all CLASSES*2^TUPLE counter addresses
// before any word is accepted; configuration writes are taken during it.
module wisard_classifier_bleaching_core #(
	parameter int CLASSES    = wcb_pkg::CLASSES_DEF,
	parameter int PIXELS     = wcb_pkg::PIXELS_DEF,
	parameter int TUPLE      = wcb_pkg::TUPLE_DEF,
	parameter int COUNT_BITS = wcb_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [63:0] image_bits,
	input  logic [2:0]  class_label,
	input  logic [5:0]  map_slot,
	input  logic [5:0]  map_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  winner,
	output logic [1:0]  status,
	output logic [4:0]  top_score,
	output logic [7:0]  bleach_level,
	output logic [7:0]  tie_mask,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import wcb_pkg::*;
	localparam int NEURONS = PIXELS / TUPLE;
	localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int SW = $clog2(NEURONS + 1);
	localparam int CLRW = CW + TUPLE;
	localparam int CLR_LAST = CLASSES * (1 << TUPLE) - 1;

	// Configuration registers are always writable.
	logic       bleach_q;
	logic [3:0] ccount_q;
	logic [4:0] kuse;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bleach_q <= 1'b1;
			ccount_q <= 4'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BLEACH:  bleach_q <= cfg_data[0];
				CFG_CLASSES: ccount_q <= cfg_data;
				default: ;
			endcase
		end
	end
	always_comb begin
		if (ccount_q == 4'd0) kuse = 5'd1;
		else if (5'(ccount_q) > 5'(CLASSES)) kuse = 5'(CLASSES);
		else kuse = 5'(ccount_q);
	end

	// Slot map registers, reset to identity; each slot read at a fixed lane place.
	logic [5:0] map_q [PIXELS];
	logic       acc;
	assign acc = in_valid && in_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < PIXELS; s++) map_q[s] <= 6'(s);
		end else if (acc && cmd == CMD_LOAD && 7'(map_slot) < 7'(PIXELS)) begin
			map_q[map_slot[$clog2(PIXELS)-1:0]] <= map_pixel;
		end
	end

	// Neuron addresses are formed from the accepted image and held for the item.
	logic [TUPLE-1:0] addr_q [NEURONS];
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int n = 0; n < NEURONS; n++) begin
				for (int j = 0; j < TUPLE; j++) begin
					addr_q[n][TUPLE-1-j] <= (7'(map_q[n*TUPLE+j]) < 7'(PIXELS))
						? image_bits[map_q[n*TUPLE+j]] : 1'b0;
				end
			end
		end
	end

	state_t state_q, state_d;
	logic [CLRW-1:0] clr_q;
	logic [CW-1:0]   cls_q;
	logic [CW-1:0]   lab_q;
	logic [7:0]      level_q;
	logic [7:0]      trained_q;
	logic            sv_s1, st_s1;
	logic [CW-1:0]   cls_s1;
	logic            last_cls;
	lane_ctl_t       ctl;
	logic [NEURONS-1:0] hits;
	logic [SW-1:0]   top;
	logic [CW-1:0]   best;
	logic [CLASSES-1:0] mask;
	logic [4:0]      ties;

	assign last_cls = 5'(cls_q) == kuse - 5'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == CLRW'(CLR_LAST)) state_d = S_IDLE;
			S_IDLE: if (acc) begin
				if (cmd == CMD_TRAIN && 5'(class_label) < kuse) state_d = S_TRAIN;
				else if (cmd == CMD_CLASS) state_d = (trained_q == 8'd0) ? S_OUT : S_SCORE;
			end
			S_TRAIN: state_d = S_IDLE;
			S_SCORE: if (last_cls) state_d = S_DECIDE;
			S_DECIDE: if (!sv_s1) begin
				if (ties == 5'd1 || top == '0 || !bleach_q || level_q + 8'd1 >= trained_q)
					state_d = S_OUT;
				else state_d = S_SCORE;
			end
			S_OUT: if (!out_valid || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.clear = state_q == S_CLEAR;
		ctl.train = state_q == S_TRAIN;
		ctl.score = state_q == S_SCORE;
		in_ready  = state_q == S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cls_q     <= '0;
			level_q   <= '0;
			trained_q <= '0;
			sv_s1     <= 1'b0;
			st_s1     <= 1'b0;
			cls_s1    <= '0;
			lab_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.clear) clr_q <= clr_q + 1'b1;
			sv_s1  <= ctl.score;
			st_s1  <= ctl.score && cls_q == '0;
			cls_s1 <= cls_q;
			if (state_q == S_IDLE && acc) begin
				lab_q   <= CW'(class_label);
				cls_q   <= '0;
				level_q <= '0;
			end
			if (ctl.train && trained_q != 8'hFF) trained_q <= trained_q + 8'd1;
			if (ctl.score) cls_q <= last_cls ? '0 : cls_q + 1'b1;
			if (state_q == S_DECIDE && state_d == S_SCORE) level_q <= level_q + 8'd1;
			// A new word replaces a taken one in the same cycle; otherwise taking clears it.
			if (state_q == S_OUT && state_d == S_IDLE) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Result word register, loaded as the item leaves.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && state_d == S_IDLE) begin
			if (trained_q == 8'd0) begin
				winner <= '0; status <= ST_UNTRAIN; top_score <= '0;
				bleach_level <= '0; tie_mask <= '0;
			end else begin
				winner       <= 3'(best);
				top_score    <= (32'(top) > 31) ? 5'd31 : 5'(top);
				bleach_level <= level_q;
				tie_mask     <= 8'(mask);
				if (ties == 5'd1) status <= ST_UNIQUE;
				else if (top == '0) status <= ST_ZERO;
				else status <= ST_TIE;
			end
		end
	end

	// Training reads the label's counters in the train state; scoring sweeps classes.
	for (genvar n = 0; n < NEURONS; n++) begin : g_lane
		wcb_lane #(.CLASSES(CLASSES), .TUPLE(TUPLE),
			.COUNT_BITS(COUNT_BITS), .CW(CW)) u_lane (
			.clk(clk), .ctl(ctl), .addr(addr_q[n]),
			.cls(ctl.train ? lab_q : cls_q),
			.clr_cls(clr_q[CLRW-1:TUPLE]), .clr_addr(clr_q[TUPLE-1:0]),
			.level(level_q), .hit(hits[n])
		);
	end

	wcb_merge #(.CLASSES(CLASSES), .NEURONS(NEURONS), .CW(CW), .SW(SW)) u_merge (
		.clk(clk), .start(st_s1), .valid(sv_s1), .cls(cls_s1), .hits(hits),
		.top(top), .best(best), .mask(mask), .ties(ties)
	);

	// A result word appears only on leaving the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT) else $error("stray result");
	// No word is taken during the clearing pass.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready) else $error("ready while clearing");
	// The bleach level never passes the trained count.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCORE |-> level_q < trained_q) else $error("level overrun");
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the WiSARD bleaching classifier core, with a built-in score predictor.
`timescale 1ns / 100ps

module tb;
	import wcb_pkg::*;

	// Decision word as it leaves the core.
	typedef struct packed {
		logic [2:0] winner;
		logic [1:0] status;
		logic [4:0] top;
		logic [7:0] level;
		logic [7:0] mask;
	} decision_t;

	// One row of the directed table. When chk is set the typed decision is expected,
	// otherwise the predictor supplies it.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] img;
		logic [2:0]  lbl;
		logic [5:0]  slot;
		logic [5:0]  pix;
		logic        chk;
		decision_t   dec;
	} dir_row_t;

	localparam int  DIR_ROWS   = 16;
	localparam int  CYCLE_CAP  = 8_000_000;
	localparam int  PHASE_WORDS = 100;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// The rows hit the untrained case, map extremes, a clean unique winner,
	// a tie at zero score, training against the highest label and the unused command.
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{CMD_CLASS, ONES, 3'd0, 6'd0, 6'd0, 1'b1, '{3'd0, ST_UNTRAIN, 5'd0, 8'd0, 8'h00}},
		'{CMD_LOAD, 64'd0, 3'd0, 6'd0, 6'd63, 1'b0, '0},
		'{CMD_LOAD, 64'd0, 3'd0, 6'd63, 6'd0, 1'b0, '0},
		'{CMD_TRAIN, ONES, 3'd7, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_CLASS, ONES, 3'd0, 6'd0, 6'd0, 1'b1, '{3'd7, ST_UNIQUE, 5'd16, 8'd0, 8'h80}},
		'{CMD_CLASS, 64'd0, 3'd0, 6'd0, 6'd0, 1'b1, '{3'd0, ST_ZERO, 5'd0, 8'd0, 8'hFF}},
		'{CMD_TRAIN, 64'd0, 3'd0, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_CLASS, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_TRAIN, ONES, 3'd7, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_TRAIN, 64'h0F0F_3C3C_F0F0_C3C3, 3'd3, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_CLASS, 64'h0F0F_3C3C_F0F0_C3C3, 3'd0, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_TRAIN, 64'h0F0F_3C3C_F0F0_C3C3, 3'd5, 6'd0, 6'd0, 1'b0, '0},
		'{CMD_CLASS, 64'h0F0F_3C3C_F0F0_C3C3, 3'd0, 6'd0, 6'd0, 1'b0, '0},
		'{2'd3, ONES, 3'd7, 6'd63, 6'd63, 1'b0, '0},
		'{CMD_LOAD, 64'd0, 3'd0, 6'd5, 6'd40, 1'b0, '0},
		'{CMD_CLASS, ONES, 3'd0, 6'd0, 6'd0, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [63:0] image_bits;
	logic [2:0]  class_label;
	logic [5:0]  map_slot;
	logic [5:0]  map_pixel;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  winner;
	logic [1:0]  status;
	logic [4:0]  top_score;
	logic [7:0]  bleach_level;
	logic [7:0]  tie_mask;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [3:0]  cfg_data;

	wisard_classifier_bleaching_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.image_bits  (image_bits),
		.class_label (class_label),
		.map_slot    (map_slot),
		.map_pixel   (map_pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.winner      (winner),
		.status      (status),
		.top_score   (top_score),
		.bleach_level(bleach_level),
		.tie_mask    (tie_mask),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Shadow copy of the core's state: counters per class, neuron and address,
	// the slot-to-pixel map, the trained-image count and both registers.
	logic [7:0] hits [8][16][16];
	logic [5:0] pix_map [64];
	int         trained;
	logic       bleach_on;
	logic [3:0] class_reg;

	decision_t  pending_scores [$];
	int         mismatches;
	int         cycles;
	int         stall_mode;
	int         burst_left;
	logic [63:0] protos [4];

	always #10 clk = ~clk;

	// Zero maps to one class and anything above eight is clamped to eight.
	function automatic int live_classes();
		if (class_reg == 4'd0)
			return 1;
		if (class_reg > 4'd8)
			return 8;
		return int'(class_reg);
	endfunction

	// Gathers the tuple address of one neuron; the first slot lands in the MSB.
	function automatic logic [3:0] tuple_addr(input int n, input logic [63:0] img);
		logic [3:0] a;
		a = '0;
		for (int j = 0; j < 4; j++)
			a = {a[2:0], img[pix_map[n * 4 + j]]};
		return a;
	endfunction

	function automatic void train_image(input logic [63:0] img, input logic [2:0] lbl);
		logic [3:0] a;
		if (int'(lbl) >= live_classes())
			return;
		for (int n = 0; n < 16; n++) begin
			a = tuple_addr(n, img);
			if (hits[lbl][n][a] != 8'hFF)
				hits[lbl][n][a] = hits[lbl][n][a] + 8'd1;
		end
		if (trained < 255)
			trained++;
	endfunction

	// Scores all live classes level by level, raising the bleach level while ties
	// stand with a nonzero top score and bleaching is on.
	function automatic decision_t score_image(input logic [63:0] img);
		decision_t  r;
		logic [3:0] a [16];
		int         sc [8];
		int         k;
		int         top;
		int         best;
		int         ties;
		logic [7:0] mask;
		r = '0;
		r.status = ST_UNTRAIN;
		k = live_classes();
		for (int n = 0; n < 16; n++)
			a[n] = tuple_addr(n, img);
		for (int lvl = 0; lvl < trained; lvl++) begin
			for (int c = 0; c < k; c++) begin
				sc[c] = 0;
				for (int n = 0; n < 16; n++)
					if (int'(hits[c][n][a[n]]) > lvl)
						sc[c]++;
			end
			best = 0;
			top = sc[0];
			for (int c = 1; c < k; c++)
				if (sc[c] > top) begin
					top = sc[c];
					best = c;
				end
			ties = 0;
			mask = '0;
			for (int c = 0; c < k; c++)
				if (sc[c] == top) begin
					ties++;
					mask[c] = 1'b1;
				end
			r.level = lvl[7:0];
			r.winner = best[2:0];
			r.top = (top > 31) ? 5'd31 : top[4:0];
			r.mask = mask;
			if (ties == 1) begin
				r.status = ST_UNIQUE;
				break;
			end
			if (top == 0) begin
				r.status = ST_ZERO;
				break;
			end
			r.status = ST_TIE;
			if (!bleach_on)
				break;
		end
		return r;
	endfunction

	// Every input word passes through here. The word is held until the core takes it;
	// the shadow state is updated at acceptance, and a classify queues its decision.
	task automatic send_word(input logic [1:0] c, input logic [63:0] img, input logic [2:0] lbl,
			input logic [5:0] slot, input logic [5:0] pix, input logic chk, input decision_t dec);
		int gap;
		// Bursts of random length separated by random gaps; stall mode 0 sends back to back.
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (stall_mode == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		cmd = c;
		image_bits = img;
		class_label = lbl;
		map_slot = slot;
		map_pixel = pix;
		do
			@(posedge clk);
		while (!in_ready);
		case (c)
			CMD_LOAD: pix_map[slot] = pix;
			CMD_TRAIN: train_image(img, lbl);
			CMD_CLASS: pending_scores.push_back(chk ? dec : score_image(img));
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Drops the input valid and waits for all decisions plus a margin that covers
	// the longest train or load still in flight.
	task automatic drain();
		in_valid = 1'b0;
		while (pending_scores.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_BLEACH)
			bleach_on = val[0];
		else
			class_reg = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Training images are mostly noisy copies of a few prototypes so that classes
	// overlap and ties, bleaching and deep levels actually occur.
	function automatic logic [63:0] pick_image();
		logic [63:0] noise;
		if ($urandom_range(0, 4) == 0)
			return {$urandom, $urandom};
		noise = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
		if ($urandom_range(0, 2) == 0)
			noise = '0;
		return protos[$urandom_range(0, 3)] ^ noise;
	endfunction

	task automatic random_phase(input int words);
		int sel;
		for (int p = 0; p < 4; p++)
			protos[p] = {$urandom, $urandom};
		for (int i = 0; i < words; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				send_word(CMD_LOAD, {$urandom, $urandom}, 3'($urandom), 6'($urandom),
					6'($urandom), 1'b0, '0);
			else if (sel < 52)
				send_word(CMD_TRAIN, pick_image(), 3'($urandom), 6'($urandom),
					6'($urandom), 1'b0, '0);
			else if (sel < 96)
				send_word(CMD_CLASS, pick_image(), 3'($urandom), 6'($urandom),
					6'($urandom), 1'b0, '0);
			else
				send_word(2'd3, {$urandom, $urandom}, 3'($urandom), 6'($urandom),
					6'($urandom), 1'b0, '0);
		end
	endtask

	// The receiver stall pattern depends on the phase: always ready, coin flip,
	// or ready with a chance of one in four.
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Decision checker: every accepted word is matched against the oldest expectation.
	always @(posedge clk) begin
		decision_t got;
		decision_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{winner, status, top_score, bleach_level, tie_mask};
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected decision word %p", got);
			end else begin
				want = pending_scores.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: decision mismatch expected %p actual %p", want, got);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		image_bits = '0;
		class_label = '0;
		map_slot = '0;
		map_pixel = '0;
		out_ready = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = CFG_BLEACH;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		stall_mode = 0;
		burst_left = 0;
		trained = 0;
		bleach_on = 1'b1;
		class_reg = 4'd8;
		for (int c = 0; c < 8; c++)
			for (int n = 0; n < 16; n++)
				for (int a = 0; a < 16; a++)
					hits[c][n][a] = '0;
		for (int s = 0; s < 64; s++)
			pix_map[s] = s[5:0];

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed table with the reset register values.
		for (int r = 0; r < DIR_ROWS; r++)
			send_word(dir_tab[r].cmd, dir_tab[r].img, dir_tab[r].lbl, dir_tab[r].slot,
				dir_tab[r].pix, dir_tab[r].chk, dir_tab[r].dec);
		drain();

		// Random phases, each under its own register setting and one of the three stall patterns.
		// Covered: bleaching off, a single class, class count zero and above eight.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_BLEACH, 4'd1); write_reg(CFG_CLASSES, 4'd8); end
				1: begin write_reg(CFG_BLEACH, 4'd0); write_reg(CFG_CLASSES, 4'd3); end
				2: begin write_reg(CFG_BLEACH, 4'd1); write_reg(CFG_CLASSES, 4'd1); end
				3: begin write_reg(CFG_BLEACH, 4'd1); write_reg(CFG_CLASSES, 4'd0); end
				4: begin write_reg(CFG_BLEACH, 4'd0); write_reg(CFG_CLASSES, 4'd15); end
				default: begin write_reg(CFG_BLEACH, 4'd1); write_reg(CFG_CLASSES, 4'd5); end
			endcase
			stall_mode = ph % 3;
			random_phase(PHASE_WORDS);
			drain();
		end

		if (mismatches == 0 && pending_scores.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* filelist.f */
design/wcb_pkg.sv
design/wcb_lane.sv
design/wcb_merge.sv
design/wisard_classifier_bleaching_core.sv
tb/sv/tb.sv
